// ===== hw/rtl/tpd_pkg.sv =====
// Shared types and constants for the tiled palette pixel decoder.
// Holds the input and output word layouts, operation codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpd_pkg;

	localparam int unsigned TILE_SIDE      = 8;
	localparam int unsigned TILE_SIDE_LOG2 = 3;
	localparam int unsigned TILE_PIX_W     = 2 * TILE_SIDE_LOG2;
	localparam int unsigned COLOUR_W       = 8;
	localparam int unsigned RGB_W          = 3 * COLOUR_W;
	localparam int unsigned CFG_DIM_W      = 11;
	localparam int unsigned CFG_DATA_W     = CFG_DIM_W;
	localparam int unsigned CFG_INDEX_W    = 2;
	localparam int unsigned PIXEL_INDEX_W  = 20;
	localparam int unsigned SLOT_W         = 8;

	localparam int unsigned MAX_WIDTH_DEF       = 1024;
	localparam int unsigned MAX_HEIGHT_DEF      = 1024;
	localparam int unsigned PALETTE_ENTRIES_DEF = 256;

	localparam logic                 FOUR_BIT_MODE_RST = 1'b1;
	localparam logic [CFG_DIM_W-1:0] IMAGE_WIDTH_RST   = 11'd256;
	localparam logic [CFG_DIM_W-1:0] IMAGE_HEIGHT_RST  = 11'd192;

	localparam logic [COLOUR_W-1:0] ALPHA_CLEAR  = 8'h00;
	localparam logic [COLOUR_W-1:0] ALPHA_OPAQUE = 8'hFF;

	typedef enum logic [1:0] {
		OP_PALETTE_WRITE = 2'd0,
		OP_TILE_BYTE     = 2'd1,
		OP_RESTART       = 2'd2
	} op_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_FOUR_BIT_MODE = 2'd0,
		REG_IMAGE_WIDTH   = 2'd1,
		REG_IMAGE_HEIGHT  = 2'd2
	} reg_index_t;

	typedef struct packed {
		logic [1:0]          operation;
		logic [7:0]          data_byte;
		logic [SLOT_W-1:0]   palette_slot;
		logic [COLOUR_W-1:0] red_in;
		logic [COLOUR_W-1:0] green_in;
		logic [COLOUR_W-1:0] blue_in;
	} item_word_t;

	typedef struct packed {
		logic [PIXEL_INDEX_W-1:0] pixel_index;
		logic [COLOUR_W-1:0]      red_out;
		logic [COLOUR_W-1:0]      green_out;
		logic [COLOUR_W-1:0]      blue_out;
		logic [COLOUR_W-1:0]      alpha_out;
		logic                     last_of_run;
	} pixel_word_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tpd_palette.sv =====
// Palette memory: one write port and two registered read ports.
// Entries never written read as zero through per-entry valid bits.
// Depends on tpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tpd_palette #(
	parameter int unsigned ENTRIES = tpd_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [$clog2(ENTRIES)-1:0]    wr_addr,
	input  wire logic [tpd_pkg::RGB_W-1:0]     wr_data,
	input  wire logic                          rd_en,
	input  wire logic [$clog2(ENTRIES)-1:0]    rd_addr_a,
	input  wire logic [$clog2(ENTRIES)-1:0]    rd_addr_b,
	output      logic [tpd_pkg::RGB_W-1:0]     rd_data_a,
	output      logic [tpd_pkg::RGB_W-1:0]     rd_data_b
);

	logic [tpd_pkg::RGB_W-1:0] mem [ENTRIES];
	logic [ENTRIES-1:0]        vld_q;
	logic [tpd_pkg::RGB_W-1:0] rd_a_q;
	logic [tpd_pkg::RGB_W-1:0] rd_b_q;
	logic                      rd_a_vld_q;
	logic                      rd_b_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_a_q <= mem[rd_addr_a];
			rd_b_q <= mem[rd_addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_a_vld_q <= 1'b0;
			rd_b_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_a_vld_q <= vld_q[rd_addr_a];
				rd_b_vld_q <= vld_q[rd_addr_b];
			end
		end
	end

	// unwritten entries read as zero through their valid bits
	assign rd_data_a = rd_a_vld_q ? rd_a_q : '0;
	assign rd_data_b = rd_b_vld_q ? rd_b_q : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/tiled_palette_pixel_decoder_core.sv =====
// Top level of the tiled palette pixel decoder: tile walk, pixel hold stage
// and output register. Depends on tpd_pkg and tpd_palette.
//
//  channel  | signals                          | direction | word
//  ---------+----------------------------------+-----------+-------------------
//  item     | item_valid, item_ready, item     | in        | tpd_pkg::item_word_t
//  pixel    | pixel_valid, pixel_ready, pixel  | out       | tpd_pkg::pixel_word_t
//  register | reg_write_en, reg_index, reg_data| in        | 11-bit write data
//
// One item is taken per cycle while item_ready is high; the palette read happens at
// acceptance and the pixel then leaves through the output register.
// The pixel port passes one word per cycle unless stalled, so a 4 bpp byte with both
// pixels visible holds the input until its first pixel is out; 8 bpp bytes flow at one per cycle.
// Reset clears the position, the palette valid bits and the registers; there
// is no clearing pass. A stalled pixel port holds one word plus one pending byte.
`timescale 1ns / 1ps
`default_nettype none

module tiled_palette_pixel_decoder_core #(
	parameter int unsigned MAX_WIDTH       = tpd_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_HEIGHT      = tpd_pkg::MAX_HEIGHT_DEF,
	parameter int unsigned PALETTE_ENTRIES = tpd_pkg::PALETTE_ENTRIES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              item_valid,
	output      logic                              item_ready,
	input  wire tpd_pkg::item_word_t               item,
	output      logic                              pixel_valid,
	input  wire logic                              pixel_ready,
	output      tpd_pkg::pixel_word_t              pixel,
	input  wire logic                              reg_write_en,
	input  wire logic [tpd_pkg::CFG_INDEX_W-1:0]   reg_index,
	input  wire logic [tpd_pkg::CFG_DATA_W-1:0]    reg_data
);

	localparam int unsigned TS     = tpd_pkg::TILE_SIDE;
	localparam int unsigned TSL    = tpd_pkg::TILE_SIDE_LOG2;
	localparam int unsigned TPW    = tpd_pkg::TILE_PIX_W;
	localparam int unsigned TX_MAX = (MAX_WIDTH + TS - 1) / TS;
	localparam int unsigned TY_MAX = (MAX_HEIGHT + TS - 1) / TS;
	localparam int unsigned CW     = (TX_MAX > 1) ? $clog2(TX_MAX) : 1;
	localparam int unsigned RW     = (TY_MAX > 1) ? $clog2(TY_MAX) : 1;
	localparam int unsigned WW     = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HW     = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned DW0    = (WW > HW) ? WW : HW;
	localparam int unsigned DW     = (DW0 > tpd_pkg::CFG_DIM_W) ? DW0 : tpd_pkg::CFG_DIM_W;
	localparam int unsigned SW     = (2 * DW + 1 > tpd_pkg::PIXEL_INDEX_W) ?
		2 * DW + 1 : tpd_pkg::PIXEL_INDEX_W;
	localparam int unsigned AW     = $clog2(PALETTE_ENTRIES);
	localparam int unsigned CMW    = tpd_pkg::SLOT_W + 1;

	typedef struct packed {
		logic [CW-1:0]  col;
		logic [RW-1:0]  row;
		logic [TPW-1:0] pit;
		logic           done;
	} pos_t;

	// config registers
	logic                            four_bit_q;
	logic [tpd_pkg::CFG_DIM_W-1:0]   width_q;
	logic [tpd_pkg::CFG_DIM_W-1:0]   height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			four_bit_q <= tpd_pkg::FOUR_BIT_MODE_RST;
			width_q    <= tpd_pkg::IMAGE_WIDTH_RST;
			height_q   <= tpd_pkg::IMAGE_HEIGHT_RST;
		end else if (reg_write_en) begin
			case (reg_index)
				tpd_pkg::REG_FOUR_BIT_MODE: four_bit_q <= reg_data[0];
				tpd_pkg::REG_IMAGE_WIDTH:   width_q    <= reg_data;
				tpd_pkg::REG_IMAGE_HEIGHT:  height_q   <= reg_data;
				default: ;
			endcase
		end
	end

	// clamped image size and tile counts
	logic [DW-1:0]   w_eff;
	logic [DW-1:0]   h_eff;
	logic [DW:0]     w_round;
	logic [DW:0]     h_round;
	logic [CW:0]     tiles_x;
	logic [RW:0]     tiles_y;

	always_comb begin
		if (width_q == '0) begin
			w_eff = DW'(1);
		end else if (DW'(width_q) > DW'(MAX_WIDTH)) begin
			w_eff = DW'(MAX_WIDTH);
		end else begin
			w_eff = DW'(width_q);
		end
		if (height_q == '0) begin
			h_eff = DW'(1);
		end else if (DW'(height_q) > DW'(MAX_HEIGHT)) begin
			h_eff = DW'(MAX_HEIGHT);
		end else begin
			h_eff = DW'(height_q);
		end
		w_round = (DW + 1)'(w_eff) + (DW + 1)'(TS - 1);
		h_round = (DW + 1)'(h_eff) + (DW + 1)'(TS - 1);
		tiles_x = (CW + 1)'(w_round >> TSL);
		tiles_y = (RW + 1)'(h_round >> TSL);
	end

	// one step through the tile walk
	function automatic pos_t step_pos(input pos_t p, input logic [CW:0] tx,
			input logic [RW:0] ty);
		pos_t        n;
		logic [CW:0] col_nx;
		logic [RW:0] row_nx;
		n      = p;
		col_nx = {1'b0, p.col} + (CW + 1)'(1);
		row_nx = {1'b0, p.row} + (RW + 1)'(1);
		n.pit  = p.pit + TPW'(1);
		if (p.pit == {TPW{1'b1}}) begin
			n.col = col_nx[CW-1:0];
			if (col_nx >= tx) begin
				n.col = '0;
				n.row = row_nx[RW-1:0];
				if (row_nx >= ty) begin
					n.row  = '0;
					n.done = 1'b1;
				end
			end
		end
		return n;
	endfunction

	pos_t pos_q;
	pos_t pos_a_nx;
	pos_t pos_b_nx;

	logic          item_acc;
	logic          take_byte;
	logic          has_b;
	logic [DW-1:0] x_a;
	logic [DW-1:0] y_a;
	logic [DW-1:0] x_b;
	logic [DW-1:0] y_b;
	logic          vis_a;
	logic          vis_b;
	logic [3:0]    lo_nib;
	logic [3:0]    hi_nib;
	logic [7:0]    idx_a;
	logic [7:0]    idx_b;
	logic          pal_wr;

	assign item_acc  = item_valid && item_ready;
	assign take_byte = item_acc && (item.operation == tpd_pkg::OP_TILE_BYTE) && !pos_q.done;
	assign pal_wr    = item_acc && (item.operation == tpd_pkg::OP_PALETTE_WRITE) &&
		(CMW'(item.palette_slot) < CMW'(PALETTE_ENTRIES));

	always_comb begin
		pos_a_nx = step_pos(pos_q, tiles_x, tiles_y);
		pos_b_nx = step_pos(pos_a_nx, tiles_x, tiles_y);
		has_b    = four_bit_q && !pos_a_nx.done;
		x_a      = DW'({pos_q.col, pos_q.pit[TSL-1:0]});
		y_a      = DW'({pos_q.row, pos_q.pit[TPW-1:TSL]});
		x_b      = DW'({pos_a_nx.col, pos_a_nx.pit[TSL-1:0]});
		y_b      = DW'({pos_a_nx.row, pos_a_nx.pit[TPW-1:TSL]});
		vis_a    = (x_a < w_eff) && (y_a < h_eff);
		vis_b    = has_b && (x_b < w_eff) && (y_b < h_eff);
		lo_nib   = item.data_byte[3:0];
		hi_nib   = item.data_byte[7:4];
		idx_a    = four_bit_q ? {4'd0, lo_nib} : item.data_byte;
		idx_b    = {4'd0, hi_nib};
	end

	// tile position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (item_acc && item.operation == tpd_pkg::OP_RESTART) begin
			pos_q <= '0;
		end else if (take_byte) begin
			pos_q <= has_b ? pos_b_nx : pos_a_nx;
		end
	end

	logic [tpd_pkg::RGB_W-1:0] rgb_a;
	logic [tpd_pkg::RGB_W-1:0] rgb_b;

	tpd_palette #(
		.ENTRIES (PALETTE_ENTRIES)
	) u_palette (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (pal_wr),
		.wr_addr   (item.palette_slot[AW-1:0]),
		.wr_data   ({item.red_in, item.green_in, item.blue_in}),
		.rd_en     (take_byte),
		.rd_addr_a (idx_a[AW-1:0]),
		.rd_addr_b (idx_b[AW-1:0]),
		.rd_data_a (rgb_a),
		.rd_data_b (rgb_b)
	);

	// hold stage: up to two visible pixels of one byte
	logic [1:0]    pend_s1;
	logic [DW-1:0] x_s1 [2];
	logic [DW-1:0] y_s1 [2];
	logic [1:0]    zero_s1;
	logic [1:0]    ok_s1;

	logic          out_free;
	logic          load;
	logic          sel;
	logic [1:0]    sel_mask;

	assign out_free   = !pixel_valid || pixel_ready;
	assign load       = (pend_s1 != 2'b00) && out_free;
	assign sel        = !pend_s1[0];
	assign sel_mask   = sel ? 2'b10 : 2'b01;
	assign item_ready = (pend_s1 == 2'b00) || (out_free && (pend_s1[0] ^ pend_s1[1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 2'b00;
		end else if (take_byte) begin
			pend_s1 <= {vis_b, vis_a};
		end else if (load) begin
			pend_s1 <= pend_s1 & ~sel_mask;
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte) begin
			x_s1[0]    <= x_a;
			y_s1[0]    <= y_a;
			x_s1[1]    <= x_b;
			y_s1[1]    <= y_b;
			zero_s1[0] <= (idx_a == 8'd0);
			zero_s1[1] <= (idx_b == 8'd0);
			ok_s1[0]   <= (CMW'(idx_a) < CMW'(PALETTE_ENTRIES));
			ok_s1[1]   <= (CMW'(idx_b) < CMW'(PALETTE_ENTRIES));
		end
	end

	// output register
	logic [DW-1:0]             x_sel;
	logic [DW-1:0]             y_sel;
	logic [2*DW-1:0]           row_base;
	logic [SW-1:0]             lin_sum;
	logic [tpd_pkg::RGB_W-1:0] rgb_sel;
	tpd_pkg::pixel_word_t      pix_nx;

	always_comb begin
		x_sel    = x_s1[sel];
		y_sel    = y_s1[sel];
		row_base = (2 * DW)'(y_sel) * (2 * DW)'(w_eff);
		lin_sum  = SW'(row_base) + SW'(x_sel);
		rgb_sel  = ok_s1[sel] ? (sel ? rgb_b : rgb_a) : '0;
		pix_nx.pixel_index = lin_sum[tpd_pkg::PIXEL_INDEX_W-1:0];
		pix_nx.red_out     = rgb_sel[tpd_pkg::RGB_W-1 -: tpd_pkg::COLOUR_W];
		pix_nx.green_out   = rgb_sel[tpd_pkg::COLOUR_W +: tpd_pkg::COLOUR_W];
		pix_nx.blue_out    = rgb_sel[tpd_pkg::COLOUR_W-1:0];
		pix_nx.alpha_out   = zero_s1[sel] ? tpd_pkg::ALPHA_CLEAR : tpd_pkg::ALPHA_OPAQUE;
		// last word of the byte unless the second pixel still waits
		pix_nx.last_of_run = sel || !pend_s1[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (out_free) begin
			pixel_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pixel <= pix_nx;
		end
	end

`ifndef SYNTHESIS
	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_s1 == 2'b11) |-> !item_ready)
		else $error("byte taken while both pixels of the previous byte wait");

	a_done_at_origin: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q.done |-> (pos_q.col == '0 && pos_q.row == '0 && pos_q.pit == '0))
		else $error("image complete with position not at first tile");

	a_not_last_keeps_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(load && !pix_nx.last_of_run) |=> pend_s1[1])
		else $error("second pixel lost after a word not marked last");
`endif

endmodule

`default_nettype wire

// ===== tb/tiled_palette_pixel_decoder_core_tb.sv =====
// Self-checking testbench for tiled_palette_pixel_decoder_core.
// Predicts each pixel word from accepted items and checks the pixel stream in order.
// Depends on tpd_pkg and the core RTL only.
`timescale 1ns / 1ps

module tiled_palette_pixel_decoder_core_tb;

	import tpd_pkg::*;

	localparam int unsigned TILE_PIXELS  = TILE_SIDE * TILE_SIDE;
	localparam logic [1:0]  OP_UNKNOWN   = 2'd3;
	localparam int unsigned RANDOM_ITEMS = 450;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned LIMIT_CYCLES = 500000;

	// Expected-pixel store: mirrors the tile walk and palette of the core.
	class pixel_scoreboard;
		logic [RGB_W-1:0]         palette_rgb [PALETTE_ENTRIES_DEF];
		int unsigned              tile_col;
		int unsigned              tile_row;
		int unsigned              pix_in_tile;
		bit                       image_done;
		bit                       bpp4;
		logic [CFG_DIM_W-1:0]     width_reg;
		logic [CFG_DIM_W-1:0]     height_reg;
		pixel_word_t              expected_pixels [$];
		int unsigned              mismatches;

		function new();
			foreach (palette_rgb[i])
				palette_rgb[i] = '0;
			tile_col    = 0;
			tile_row    = 0;
			pix_in_tile = 0;
			image_done  = 1'b0;
			bpp4        = FOUR_BIT_MODE_RST;
			width_reg   = IMAGE_WIDTH_RST;
			height_reg  = IMAGE_HEIGHT_RST;
			mismatches  = 0;
		endfunction

		function void set_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_FOUR_BIT_MODE: bpp4 = value[0];
				REG_IMAGE_WIDTH:   width_reg = value;
				REG_IMAGE_HEIGHT:  height_reg = value;
				default: ;
			endcase
		endfunction

		function int unsigned clamp_dim(logic [CFG_DIM_W-1:0] value, int unsigned limit);
			if (32'(value) == 0)
				return 1;
			if (32'(value) > limit)
				return limit;
			return 32'(value);
		endfunction

		// Place one colour index at the current position, then advance the walk.
		function bit place_pixel(int unsigned colour_idx, output pixel_word_t px);
			int unsigned w = clamp_dim(width_reg, MAX_WIDTH_DEF);
			int unsigned h = clamp_dim(height_reg, MAX_HEIGHT_DEF);
			int unsigned tiles_x = (w + TILE_SIDE - 1) / TILE_SIDE;
			int unsigned tiles_y = (h + TILE_SIDE - 1) / TILE_SIDE;
			int unsigned x = tile_col * TILE_SIDE + (pix_in_tile % TILE_SIDE);
			int unsigned y = tile_row * TILE_SIDE + (pix_in_tile / TILE_SIDE);
			logic [RGB_W-1:0] rgb;
			bit visible = (x < w) && (y < h);

			px = '0;
			if (visible) begin
				rgb = (colour_idx < PALETTE_ENTRIES_DEF) ? palette_rgb[colour_idx] : '0;
				px.pixel_index = PIXEL_INDEX_W'(y * w + x);
				px.red_out     = rgb[23:16];
				px.green_out   = rgb[15:8];
				px.blue_out    = rgb[7:0];
				px.alpha_out   = (colour_idx == 0) ? ALPHA_CLEAR : ALPHA_OPAQUE;
				px.last_of_run = 1'b0;
			end
			pix_in_tile++;
			if (pix_in_tile >= TILE_PIXELS) begin
				pix_in_tile = 0;
				tile_col++;
				if (tile_col >= tiles_x) begin
					tile_col = 0;
					tile_row++;
					if (tile_row >= tiles_y) begin
						tile_row   = 0;
						image_done = 1'b1;
					end
				end
			end
			return visible;
		endfunction

		// Returns 1 when the word changes state or yields pixels, 0 when it is ignored.
		function bit note_item(item_word_t w);
			pixel_word_t px;
			pixel_word_t made [$];

			case (w.operation)
				OP_PALETTE_WRITE: begin
					if (32'(w.palette_slot) < PALETTE_ENTRIES_DEF)
						palette_rgb[w.palette_slot] = {w.red_in, w.green_in, w.blue_in};
					return 1'b1;
				end
				OP_RESTART: begin
					tile_col    = 0;
					tile_row    = 0;
					pix_in_tile = 0;
					image_done  = 1'b0;
					return 1'b1;
				end
				OP_TILE_BYTE: begin
					if (image_done)
						return 1'b0;
					if (bpp4) begin
						if (place_pixel(32'(w.data_byte[3:0]), px))
							made.push_back(px);
						if (!image_done && place_pixel(32'(w.data_byte[7:4]), px))
							made.push_back(px);
					end else if (place_pixel(32'(w.data_byte), px)) begin
						made.push_back(px);
					end
					if (made.size() != 0)
						made[made.size() - 1].last_of_run = 1'b1;
					foreach (made[i])
						expected_pixels.push_back(made[i]);
					return 1'b1;
				end
				default: return 1'b0;
			endcase
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
				mismatches++;
			end
		endfunction

		function void check_pixel(pixel_word_t got);
			pixel_word_t want;

			if (expected_pixels.size() == 0) begin
				$display("%0t: unexpected pixel word, expected none, actual %h", $time, got);
				mismatches++;
				return;
			end
			want = expected_pixels.pop_front();
			compare_field("pixel_index", 32'(want.pixel_index), 32'(got.pixel_index));
			compare_field("red_out", 32'(want.red_out), 32'(got.red_out));
			compare_field("green_out", 32'(want.green_out), 32'(got.green_out));
			compare_field("blue_out", 32'(want.blue_out), 32'(got.blue_out));
			compare_field("alpha_out", 32'(want.alpha_out), 32'(got.alpha_out));
			compare_field("last_of_run", 32'(want.last_of_run), 32'(got.last_of_run));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   item_valid;
	logic                   item_ready;
	item_word_t             item;
	logic                   pixel_valid;
	logic                   pixel_ready;
	pixel_word_t            pixel;
	logic                   reg_write_en;
	logic [CFG_INDEX_W-1:0] reg_index;
	logic [CFG_DATA_W-1:0]  reg_data;

	pixel_scoreboard sb;
	bit              src_gaps = 1'b1;
	bit              sink_stalls = 1'b1;
	int unsigned     effective_items = 0;
	int unsigned     ready_hold = 0;
	int unsigned     cycle_count = 0;

	tiled_palette_pixel_decoder_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel        (pixel),
		.reg_write_en (reg_write_en),
		.reg_index    (reg_index),
		.reg_data     (reg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Pixel sink: check each accepted word, then pick the next ready level.
	always @(posedge clk) begin : pixel_sink
		int unsigned roll;

		if (arst_n && pixel_valid && pixel_ready)
			sb.check_pixel(pixel);
		roll = $urandom_range(0, 99);
		if (ready_hold != 0) begin
			ready_hold  <= ready_hold - 1;
			pixel_ready <= 1'b0;
		end else if (!sink_stalls || roll < 65) begin
			pixel_ready <= 1'b1;
		end else begin
			pixel_ready <= 1'b0;
			ready_hold  <= (roll < 93) ? $urandom_range(0, 2) : $urandom_range(6, 30);
		end
	end

	function automatic int unsigned pick_gap();
		int unsigned roll = $urandom_range(0, 99);

		if (!src_gaps || roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 25);
	endfunction

	function automatic int unsigned pick_dim();
		if ($urandom_range(0, 99) >= 12)
			return $urandom_range(1, 20);
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 1024;
			3: return 1025;
			4: return 2047;
			default: return TILE_SIDE;
		endcase
	endfunction

	function automatic item_word_t make_word(logic [1:0] op, logic [7:0] data,
			logic [7:0] slot, logic [7:0] r, logic [7:0] g, logic [7:0] b);
		item_word_t w;

		w.operation    = op;
		w.data_byte    = data;
		w.palette_slot = slot;
		w.red_in       = r;
		w.green_in     = g;
		w.blue_in      = b;
		return w;
	endfunction

	function automatic item_word_t random_word(logic [1:0] op);
		return make_word(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom));
	endfunction

	task automatic send_item(item_word_t w);
		int unsigned gap;

		item       <= w;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (!item_ready);
		if (sb.note_item(w))
			effective_items++;
		gap = pick_gap();
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Hold the item side until every predicted word has left, then let the core settle.
	task automatic drain();
		item_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] value);
		reg_write_en <= 1'b1;
		reg_index    <= idx;
		reg_data     <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic set_regs(bit four_bit, int unsigned w, int unsigned h);
		write_reg(REG_FOUR_BIT_MODE, CFG_DATA_W'(four_bit));
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
		reg_write_en <= 1'b0;
	endtask

	initial begin
		int unsigned roll;
		int unsigned burst;
		logic [1:0]  op;

		sb           = new();
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		pixel_ready  = 1'b1;
		reg_write_en = 1'b0;
		reg_index    = REG_FOUR_BIT_MODE;
		reg_data     = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset configuration, 4 bpp at 256 x 192.
		send_item(make_word(OP_PALETTE_WRITE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_word(OP_PALETTE_WRITE, 8'hFF, 8'hFF, 8'h12, 8'h34, 8'h56));
		send_item(make_word(OP_PALETTE_WRITE, 8'h00, 8'h01, 8'h00, 8'h80, 8'hFF));
		send_item(make_word(OP_PALETTE_WRITE, 8'h00, 8'h0F, 8'hA5, 8'h5A, 8'hC3));
		send_item(make_word(OP_TILE_BYTE, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
		send_item(make_word(OP_TILE_BYTE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_word(OP_TILE_BYTE, 8'h10, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_word(OP_TILE_BYTE, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_word(OP_TILE_BYTE, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(random_word(OP_UNKNOWN));
		send_item(random_word(OP_RESTART));
		send_item(make_word(OP_TILE_BYTE, 8'h1F, 8'h00, 8'h00, 8'h00, 8'h00));

		// Directed: 8 bpp with width above the maximum and height of zero.
		drain();
		set_regs(1'b0, 2047, 0);
		send_item(make_word(OP_TILE_BYTE, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_word(OP_TILE_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_word(OP_TILE_BYTE, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(random_word(OP_RESTART));
		send_item(make_word(OP_TILE_BYTE, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00));

		// Directed: one pixel wide, full height; only column zero survives clipping.
		drain();
		set_regs(1'b1, 1, 1024);
		send_item(make_word(OP_TILE_BYTE, 8'h21, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_word(OP_TILE_BYTE, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00));
		send_item(make_word(OP_TILE_BYTE, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00));

		// Random phases; the walk position carries over each size change.
		effective_items = 0;
		while (effective_items < RANDOM_ITEMS) begin
			drain();
			set_regs(1'($urandom_range(0, 1)), pick_dim(), pick_dim());
			src_gaps    = $urandom_range(0, 3) != 0;
			sink_stalls = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 3) == 0)
				send_item(random_word(OP_RESTART));
			burst = $urandom_range(15, 50);
			repeat (burst) begin
				roll = $urandom_range(0, 99);
				if (sb.image_done && roll < 40)
					op = OP_RESTART;
				else if (roll < 8)
					op = OP_PALETTE_WRITE;
				else if (roll < 11)
					op = OP_UNKNOWN;
				else if (roll < 14)
					op = OP_RESTART;
				else
					op = OP_TILE_BYTE;
				send_item(random_word(op));
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_pixels.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== tiled_palette_pixel_decoder_core.f =====
hw/rtl/tpd_pkg.sv
hw/rtl/tpd_palette.sv
hw/rtl/tiled_palette_pixel_decoder_core.sv
tb/tiled_palette_pixel_decoder_core_tb.sv
